[src/lkc_pkg.sv]
// lkc_pkg: shared types and constants for the LRU key cache.
// Holds the request/result payload structs and the slot control struct.
// No dependencies.
package lkc_pkg;

	localparam int KEY_W = 32;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	localparam int          ADDR_W       = 3;
	localparam logic        CAPACITY_IDX = 1'b0;
	localparam logic [4:0]  CAP_RESET    = 5'd16;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic       found;
		logic       evicted;
		logic [4:0] entry_count;
	} res_t;

	typedef enum logic [1:0] {
		SLOT_HOLD,
		SLOT_PUSH,
		SLOT_FRONT,
		SLOT_PULL
	} slot_op_t;

	typedef struct packed {
		logic             cmp;
		logic             upd;
		slot_op_t         op;
		logic [KEY_W-1:0] cmp_key;
	} slot_ctl_t;

endpackage

[src/lkc_slot.sv]
// lkc_slot: one position of the recency row; holds a key and its match flag.
// On update it takes its key from the left or right input, or keeps its own.
// Depends on lkc_pkg.
module lkc_slot
	import lkc_pkg::*;
(
	input  logic             clk,
	input  slot_ctl_t        ctl,
	input  logic             live,
	input  logic [KEY_W-1:0] left_key,
	input  logic [KEY_W-1:0] right_key,
	input  logic             hit_in,
	output logic             hit_out,
	output logic             match,
	output logic [KEY_W-1:0] key_q
);

	logic             match_s2;
	logic [KEY_W-1:0] key_nxt;

	always_comb begin
		case (ctl.op)
			SLOT_PUSH:  key_nxt = left_key;
			SLOT_FRONT: key_nxt = hit_in ? key_q : left_key;
			SLOT_PULL:  key_nxt = (hit_in | match_s2) ? right_key : key_q;
			default:    key_nxt = key_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			key_q <= key_nxt;
		end
		if (ctl.cmp) begin
			match_s2 <= live && (key_q == ctl.cmp_key);
		end
	end

	assign hit_out = hit_in | match_s2;
	assign match   = match_s2;

endmodule

[src/lru_key_cache.sv]
// A transferred request is registered, then compared against every slot in the compare stage;
// the row is updated in the update stage, and the result is then on res.
// No request is taken while one is in compare; a new one may enter as the last one updates.
// A held result stalls the update step and, through it, the input.
// Reset clears occupancy, pipeline and result valids and sets capacity to 16;
// slot keys are not reset.
module lru_key_cache
	import lkc_pkg::*;
#(
	parameter int MAX_ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req,
	output logic              res_valid,
	input  logic              res_stall,
	output res_t              res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int OW = $clog2(MAX_ENTRIES + 1);
	localparam int CW = (OW > 5) ? OW : 5;

	logic             v_s1, v_s2;
	req_t             req_s1, req_s2;
	logic [OW-1:0]    occ_q;
	logic [4:0]       cap_q;
	logic             res_v_q;
	res_t             res_q;

	logic [KEY_W-1:0]     slot_key [MAX_ENTRIES];
	logic [MAX_ENTRIES:0] hit_chain;
	logic [MAX_ENTRIES-1:0] match_vec;
	logic [MAX_ENTRIES-1:0] live;

	slot_ctl_t        ctl;
	logic             upd;
	logic             hit_any;
	logic [CW-1:0]    eff_cap;
	logic [OW-1:0]    occ_after;
	logic [OW-1:0]    occ_new;
	logic             evict;
	slot_op_t         slot_op;
	res_t             res_nxt;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == CAPACITY_IDX) ? {27'b0, cap_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && paddr[2] == CAPACITY_IDX) begin
			cap_q <= pwdata[4:0];
		end
	end

	assign upd       = v_s2 & (~res_v_q | ~res_stall);
	assign req_stall = v_s1 | (v_s2 & ~upd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			res_v_q <= 1'b0;
			occ_q   <= '0;
		end else begin
			v_s1 <= req_valid & ~req_stall;
			if (v_s1) begin
				v_s2 <= 1'b1;
			end else if (upd) begin
				v_s2 <= 1'b0;
			end
			if (upd) begin
				res_v_q <= 1'b1;
				occ_q   <= occ_new;
			end else if (!res_stall) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (v_s1) begin
			req_s2 <= req_s1;
		end
		if (upd) begin
			res_q <= res_nxt;
		end
	end

	assign hit_any = hit_chain[MAX_ENTRIES];

	always_comb begin
		if (cap_q == 5'd0) begin
			eff_cap = CW'(1);
		end else if (CW'(cap_q) > CW'(MAX_ENTRIES)) begin
			eff_cap = CW'(MAX_ENTRIES);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	always_comb begin
		occ_after = hit_any ? occ_q - OW'(1) : occ_q;
		evict     = 1'b0;
		occ_new   = occ_q;
		slot_op   = SLOT_HOLD;
		case (req_s2.opcode)
			OP_INSERT: begin
				evict   = CW'(occ_after) >= eff_cap;
				occ_new = evict ? occ_after : occ_after + OW'(1);
				slot_op = hit_any ? SLOT_FRONT : SLOT_PUSH;
			end
			OP_LOOKUP: begin
				slot_op = hit_any ? SLOT_FRONT : SLOT_HOLD;
			end
			OP_DELETE: begin
				occ_new = occ_after;
				slot_op = hit_any ? SLOT_PULL : SLOT_HOLD;
			end
			default: begin
				slot_op = SLOT_HOLD;
			end
		endcase
		res_nxt.found       = hit_any && (req_s2.opcode <= OP_DELETE);
		res_nxt.evicted     = evict;
		res_nxt.entry_count = 5'(occ_new);
	end

	assign ctl.cmp     = v_s1;
	assign ctl.upd     = upd;
	assign ctl.op      = slot_op;
	assign ctl.cmp_key = req_s1.key;

	assign hit_chain[0] = 1'b0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_row
		logic [KEY_W-1:0] left_key;
		logic [KEY_W-1:0] right_key;

		assign live[i] = occ_q > OW'(i);

		if (i == 0) begin : g_first
			assign left_key = req_s2.key;
		end else begin : g_mid
			assign left_key = slot_key[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_last
			assign right_key = slot_key[i];
		end else begin : g_inner
			assign right_key = slot_key[i+1];
		end

		lkc_slot u_slot (
			.clk       (clk),
			.ctl       (ctl),
			.live      (live[i]),
			.left_key  (left_key),
			.right_key (right_key),
			.hit_in    (hit_chain[i]),
			.hit_out   (hit_chain[i+1]),
			.match     (match_vec[i]),
			.key_q     (slot_key[i])
		);
	end

	assign res_valid = res_v_q;
	assign res       = res_q;

`ifndef NO_ASSERTIONS
	a_one_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s1 && v_s2))
		else $error("compare and update stages both occupied");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(MAX_ENTRIES))
		else $error("occupancy above row length");

	a_unique_key: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $onehot0(match_vec))
		else $error("key held in more than one slot");

	a_held_item: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !upd) |=> (v_s2 && $stable(occ_q)))
		else $error("stalled request lost or state changed");
`endif

endmodule
